FILE: hw/rtl/i2c_master_byte_engine_unit_assert.svh
// Assertion macros for the I2C byte engine RTL.
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define I2CBE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define I2CBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/i2cbe_pkg.sv
// Types and constants for the I2C master byte engine.
package i2cbe_pkg;

  localparam int unsigned CFG_INDEX_WIDTH = 2;
  localparam int unsigned CFG_DATA_WIDTH  = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACK_TIMEOUT = 2'd1;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;
  localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd200;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [14:0] {
    PH_IDLE        = 15'h0001,
    PH_START_A     = 15'h0002,
    PH_START_B     = 15'h0004,
    PH_STOP_A      = 15'h0008,
    PH_STOP_B      = 15'h0010,
    PH_WR_LO       = 15'h0020,
    PH_WR_HI       = 15'h0040,
    PH_WAIT_SETTLE = 15'h0080,
    PH_WAIT_POLL   = 15'h0100,
    PH_RD_SETTLE   = 15'h0200,
    PH_RD_HOLD     = 15'h0400,
    PH_RD_LOW      = 15'h0800,
    PH_RD_HIGH     = 15'h1000,
    PH_ACK_LO      = 15'h2000,
    PH_ACK_HI      = 15'h4000
  } phase_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_output_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
  } res_t;

  typedef struct packed {
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CFG_DATA_WIDTH-1:0]  value;
  } cfg_req_t;

endpackage

FILE: hw/rtl/i2cbe_chan.sv
// Valid/ready channel carrying one payload type.
interface i2cbe_chan #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/i2c_master_byte_engine_unit.sv
// Top level of the I2C master byte engine: channels, config registers, result queue.
//
//   channel  direction  payload     moves
//   cmd      in         cmd_t       one bus tick per request
//   res      out        res_t       one line/status snapshot per tick
//   cfg      in         cfg_req_t   register index and write data
//
// One request is taken every cycle while the queue has room; its result leaves
// the queue when the consumer is ready. The path is an input register, the sequencer's
// next-state logic, and a two-entry result queue that keeps the input side
// moving while one result waits. Reset is synchronous and puts the bus lines
// high with SDA driven. A full queue stalls the cmd side; cfg never stalls.
module i2c_master_byte_engine_unit #(
  parameter int unsigned DIVIDER_WIDTH = 16
) (
  input logic      clk,
  input logic      rst,
  i2cbe_chan.sink   cmd,
  i2cbe_chan.source res,
  i2cbe_chan.sink   cfg
);
  import i2cbe_pkg::*;

  logic [15:0] half_period;
  logic [7:0]  ack_timeout;

  logic        s1_valid;
  cmd_t        s1_item;

  res_t        core_result;
  res_t        queue [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;
  logic        queue_full;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
      ack_timeout <= ACK_TIMEOUT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_HALF_PERIOD: half_period <= cfg.data.value;
        REG_ACK_TIMEOUT: ack_timeout <= cfg.data.value[7:0];
        default: begin
        end
      endcase
    end
  end

  assign queue_full = (count == 2'd2);
  assign push       = s1_valid && !queue_full;
  assign pop        = res.valid && res.ready;
  assign cmd.ready  = !s1_valid || push;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      s1_item <= cmd.data;
    end
  end

  i2cbe_core #(
    .DIVIDER_WIDTH (DIVIDER_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (push),
    .item        (s1_item),
    .half_period (half_period),
    .ack_timeout (ack_timeout),
    .result      (core_result)
  );

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= core_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign res.valid = (count != 2'd0);
  assign res.data  = queue[rd_ptr];

  `include "i2c_master_byte_engine_unit_assert.svh"

  `I2CBE_ASSERT_NOW(a_done_ends_busy, clk, rst, push && core_result.done_res,
                    !core_result.busy_res, "completion tick still reports busy")
  `I2CBE_ASSERT_NOW(a_released_sda_high, clk, rst, push && !core_result.sda_output_enable,
                    core_result.sda_out, "released SDA not reported high")
  `I2CBE_ASSERT_NOW(a_full_stalls_input, clk, rst, queue_full && s1_valid,
                    !cmd.ready, "request taken while result queue is full")
  `I2CBE_ASSERT_NEXT(a_accept_fills_stage, clk, rst, cmd.valid && cmd.ready,
                     s1_valid, "accepted request lost before the sequencer")

endmodule

FILE: hw/rtl/i2cbe_core.sv
// Bus sequencer state and its one-tick next-state logic.
module i2cbe_core #(
  parameter int unsigned DIVIDER_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  i2cbe_pkg::cmd_t   item,
  input  logic [15:0]       half_period,
  input  logic [7:0]        ack_timeout,
  output i2cbe_pkg::res_t   result
);
  import i2cbe_pkg::*;

  phase_t                   phase, phase_next;
  logic [3:0]               bit_count, bit_count_next;
  logic [7:0]               shift_reg, shift_reg_next;
  logic [DIVIDER_WIDTH-1:0] divider_count, divider_count_next;
  logic [7:0]               ack_wait_count, ack_wait_count_next;
  logic [7:0]               received_byte, received_byte_next;
  logic                     ack_flag, ack_flag_next;
  logic                     reply_ack, reply_ack_next;
  logic                     scl, scl_next;
  logic                     sda, sda_next;
  logic                     oe, oe_next;
  logic                     done;

  logic [31:0]              half_wide;
  logic [DIVIDER_WIDTH-1:0] half_cut;
  logic [DIVIDER_WIDTH-1:0] half;
  logic [DIVIDER_WIDTH-1:0] div_one;

  assign div_one   = {{(DIVIDER_WIDTH-1){1'b0}}, 1'b1};
  assign half_wide = 32'(half_period);
  assign half_cut  = half_wide[DIVIDER_WIDTH-1:0];
  // A zero half period behaves as one tick.
  assign half      = (half_cut == '0) ? div_one : half_cut;

  always_comb begin
    phase_next          = phase;
    bit_count_next      = bit_count;
    shift_reg_next      = shift_reg;
    divider_count_next  = divider_count;
    ack_wait_count_next = ack_wait_count;
    received_byte_next  = received_byte;
    ack_flag_next       = ack_flag;
    reply_ack_next      = reply_ack;
    scl_next            = scl;
    sda_next            = sda;
    oe_next             = oe;
    done                = 1'b0;

    if (phase == PH_IDLE) begin
      if (item.cmd_valid) begin
        divider_count_next = div_one;
        unique case (item.op)
          OP_START: begin
            phase_next = PH_START_A;
            scl_next = 1'b1; sda_next = 1'b1; oe_next = 1'b1;
          end
          OP_STOP: begin
            phase_next = PH_STOP_A;
            scl_next = 1'b1; sda_next = 1'b0; oe_next = 1'b1;
          end
          OP_WRITE: begin
            shift_reg_next = item.tx_byte;
            bit_count_next = '0;
            phase_next = PH_WR_LO;
            scl_next = 1'b0; sda_next = item.tx_byte[7]; oe_next = 1'b1;
          end
          default: begin
            shift_reg_next = '0;
            bit_count_next = '0;
            reply_ack_next = item.send_ack;
            phase_next = PH_RD_SETTLE;
            scl_next = 1'b1; sda_next = 1'b1; oe_next = 1'b0;
          end
        endcase
      end
    end else if (phase == PH_WAIT_POLL || phase == PH_WAIT_SETTLE && divider_count >= half)
    begin
      // The settle phase ends with a first poll in the same tick.
      if (phase == PH_WAIT_SETTLE) begin
        phase_next = PH_WAIT_POLL;
        divider_count_next = '0;
        ack_wait_count_next = '0;
      end
      if (!item.sda_in) begin
        ack_flag_next = 1'b1;
        scl_next = 1'b0;
        phase_next = PH_IDLE;
        done = 1'b1;
      end else if (ack_wait_count_next >= ack_timeout) begin
        ack_flag_next = 1'b0;
        phase_next = PH_STOP_A;
        scl_next = 1'b1; sda_next = 1'b0; oe_next = 1'b1;
        divider_count_next = div_one;
      end else begin
        ack_wait_count_next = ack_wait_count_next + 8'd1;
      end
    end else if (divider_count < half) begin
      divider_count_next = divider_count + div_one;
    end else begin
      divider_count_next = div_one;
      unique case (phase)
        PH_START_A: begin
          phase_next = PH_START_B;
          scl_next = 1'b1; sda_next = 1'b0; oe_next = 1'b1;
        end
        PH_START_B: begin
          scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
        end
        PH_STOP_A: begin
          phase_next = PH_STOP_B;
          scl_next = 1'b1; sda_next = 1'b1; oe_next = 1'b1;
        end
        PH_STOP_B: begin
          phase_next = PH_IDLE; done = 1'b1;
        end
        PH_WR_LO: begin
          phase_next = PH_WR_HI;
          scl_next = 1'b1; oe_next = 1'b1;
        end
        PH_WR_HI: begin
          shift_reg_next = {shift_reg[6:0], 1'b0};
          bit_count_next = bit_count + 4'd1;
          if (bit_count_next < BITS_PER_BYTE) begin
            phase_next = PH_WR_LO;
            scl_next = 1'b0; sda_next = shift_reg[6]; oe_next = 1'b1;
          end else begin
            phase_next = PH_WAIT_SETTLE;
            scl_next = 1'b1; sda_next = 1'b1; oe_next = 1'b0;
          end
        end
        PH_RD_SETTLE: begin
          shift_reg_next = {shift_reg[6:0], item.sda_in};
          bit_count_next = bit_count + 4'd1;
          phase_next = PH_RD_HOLD;
          scl_next = 1'b1; sda_next = 1'b1; oe_next = 1'b0;
        end
        PH_RD_HOLD: begin
          phase_next = PH_RD_LOW;
          scl_next = 1'b0; sda_next = 1'b1; oe_next = 1'b0;
        end
        PH_RD_LOW: begin
          phase_next = PH_RD_HIGH;
          scl_next = 1'b1; sda_next = 1'b1; oe_next = 1'b0;
        end
        PH_RD_HIGH: begin
          if (bit_count < BITS_PER_BYTE) begin
            shift_reg_next = {shift_reg[6:0], item.sda_in};
            bit_count_next = bit_count + 4'd1;
            phase_next = PH_RD_HOLD;
            scl_next = 1'b1; sda_next = 1'b1; oe_next = 1'b0;
          end else begin
            phase_next = PH_ACK_LO;
            scl_next = 1'b0; sda_next = ~reply_ack; oe_next = 1'b1;
          end
        end
        PH_ACK_LO: begin
          phase_next = PH_ACK_HI;
          scl_next = 1'b1; oe_next = 1'b1;
        end
        PH_ACK_HI: begin
          received_byte_next = shift_reg;
          if (reply_ack) begin
            scl_next = 1'b0;
          end
          phase_next = PH_IDLE;
          done = 1'b1;
        end
        default: begin
          // Unreachable codes fall back to idle with the lines untouched.
          divider_count_next = divider_count;
          phase_next = PH_IDLE;
        end
      endcase
    end

    if (phase_next == PH_IDLE) begin
      divider_count_next = '0;
    end
  end

  always_comb begin
    result.scl_out           = scl_next;
    result.sda_out           = oe_next ? sda_next : 1'b1;
    result.sda_output_enable = oe_next;
    result.busy_res          = (phase_next != PH_IDLE);
    result.done_res          = done;
    result.rx_byte           = received_byte_next;
    result.ack_received      = ack_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_count      <= '0;
      shift_reg      <= '0;
      divider_count  <= '0;
      ack_wait_count <= '0;
      received_byte  <= '0;
      ack_flag       <= 1'b0;
      reply_ack      <= 1'b0;
      scl            <= 1'b1;
      sda            <= 1'b1;
      oe             <= 1'b1;
    end else if (step) begin
      phase          <= phase_next;
      bit_count      <= bit_count_next;
      shift_reg      <= shift_reg_next;
      divider_count  <= divider_count_next;
      ack_wait_count <= ack_wait_count_next;
      received_byte  <= received_byte_next;
      ack_flag       <= ack_flag_next;
      reply_ack      <= reply_ack_next;
      scl            <= scl_next;
      sda            <= sda_next;
      oe             <= oe_next;
    end
  end

endmodule
